// File: rtl/core/strq_pkg.sv
// Shared types, codes and the fold arithmetic of the segment tree block.
// No dependencies; imported by segment_tree_range_query.
package strq_pkg;

  localparam int DATA_W   = 32;
  localparam int OPC_W    = 3;
  localparam int POS_W    = 11;
  localparam int FOLD_W   = 2;
  localparam int LEAVES_W = 11;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [FOLD_W-1:0] fold_op_t;
  typedef logic [OPC_W-1:0]  opcode_t;

  // Opcodes of an input beat.
  localparam opcode_t OPC_REPLACE = 3'd0;
  localparam opcode_t OPC_ADD     = 3'd1;
  localparam opcode_t OPC_COMBINE = 3'd2;
  localparam opcode_t OPC_READ    = 3'd3;
  localparam opcode_t OPC_RANGE   = 3'd4;

  // Fold operations selected by the op_select register.
  localparam fold_op_t FOLD_SUM = 2'd0;
  localparam fold_op_t FOLD_MIN = 2'd1;
  localparam fold_op_t FOLD_MAX = 2'd2;
  localparam fold_op_t FOLD_XOR = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_OP_SELECT     = 1'b0;
  localparam logic REG_ACTIVE_LEAVES = 1'b1;

  localparam logic [LEAVES_W-1:0] ACTIVE_LEAVES_RESET = 11'd1024;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Neutral element of each fold operation.
  function automatic word_t fold_identity(fold_op_t op);
    word_t id;
    case (op)
      FOLD_MIN: id = 32'h7FFF_FFFF;
      FOLD_MAX: id = 32'h8000_0000;
      default:  id = '0;
    endcase
    return id;
  endfunction

  // Applies the fold operation with a on the left and b on the right.
  function automatic word_t fold_combine(fold_op_t op, word_t a, word_t b);
    word_t res;
    case (op)
      FOLD_SUM: res = a + b;
      FOLD_MIN: res = ($signed(a) <= $signed(b)) ? a : b;
      FOLD_MAX: res = ($signed(a) >= $signed(b)) ? a : b;
      default:  res = a ^ b;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/strq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module strq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/segment_tree_range_query.sv
// Segment tree with point update and range fold over signed 32-bit leaves.
// Depends on strq_pkg and on strq_ram, which holds all tree nodes.
//
// Usage:
// An input beat carries an opcode, a position, a right bound and an operand.
// It is accepted when in_valid is high and in_stall is low. Every input beat
// yields exactly one output beat with a result value and a status, taken
// when out_valid is high and out_stall is low. One item is worked at a time;
// in_stall stays high from acceptance until the result is in the output
// register, and a new beat is accepted while that result still waits.
// Steps from acceptance to out_valid:
//   point read: a leaf read, then the result; rejected beat: the result alone;
//   update: the leaf write, then the path rebuild to the root (one node
//   memory access per tree level); range query: up to two node reads per
//   level through the single read port, in the steps QL, QR and QS.
// After reset the node memory is swept to zero, one node per cycle, over all
// 2 * span nodes (2048 for 1024 leaves); in_stall is high meanwhile.
// Configuration writes over the APB port are taken at any time, but are
// meant for an idle block. A stall on the output only holds the finished
// result; the block then waits in its final step before the next beat.
module segment_tree_range_query #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  strq_pkg::opcode_t                    in_opcode,
  input  logic [strq_pkg::POS_W-1:0]           in_position,
  input  logic [strq_pkg::POS_W-1:0]           in_right_bound,
  input  logic signed [strq_pkg::DATA_W-1:0]   in_operand_value,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [strq_pkg::DATA_W-1:0]   out_result_value,
  output logic                                 out_status,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import strq_pkg::*;

  localparam int SPAN_LOG = $clog2(LEAF_COUNT);
  localparam int NW       = SPAN_LOG + 1;
  localparam int DEPTH    = 2 ** NW;
  localparam int CNT_W    = (NW > POS_W) ? NW : POS_W;

  localparam logic [NW:0]      SPAN_EXT   = (NW + 1)'(2 ** SPAN_LOG);
  localparam logic [CNT_W-1:0] LEAF_LIMIT = CNT_W'(LEAF_COUNT);
  localparam logic [NW-1:0]    ROOT_ADDR  = NW'(1);
  localparam logic [NW-1:0]    LAST_ADDR  = NW'(DEPTH - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LEAF = 3'd2;
  localparam logic [2:0] S_UP   = 3'd3;
  localparam logic [2:0] S_QL   = 3'd4;
  localparam logic [2:0] S_QR   = 3'd5;
  localparam logic [2:0] S_QS   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [NW-1:0]       clr_r, clr_nxt;
  fold_op_t            op_sel_r, op_sel_nxt;
  logic [LEAVES_W-1:0] active_leaves_r, active_leaves_nxt;
  logic                out_valid_r, out_valid_nxt;

  opcode_t             opc_r, opc_nxt;
  logic [NW-1:0]       node_r, node_nxt;
  word_t               cur_r, cur_nxt;
  word_t               opnd_r, opnd_nxt;
  word_t               accl_r, accl_nxt;
  word_t               accr_r, accr_nxt;
  logic [NW:0]         l_r, l_nxt;
  logic [NW:0]         r_r, r_nxt;
  logic                rodd_r, rodd_nxt;
  word_t               res_r, res_nxt;
  logic                st_r, st_nxt;
  word_t               out_res_r, out_res_nxt;
  logic                out_st_r, out_st_nxt;

  logic                ram_we;
  logic [NW-1:0]       ram_waddr;
  word_t               ram_wdata;
  logic [NW-1:0]       ram_raddr;
  word_t               ram_rdata;

  logic [CNT_W-1:0]    pos_w, rb_w, al_w, n_w;
  logic                pt_ok, rg_ok;
  logic [NW-1:0]       leaf_addr;
  logic [NW-1:0]       par_addr;
  logic [NW:0]         r_dec;
  word_t               comb_a, comb_b, comb_y;
  logic                in_fire, out_free, cfg_we;

  // Node storage.
  strq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Bounds checks of the incoming beat.
  always_comb begin
    pos_w     = CNT_W'(in_position);
    rb_w      = CNT_W'(in_right_bound);
    al_w      = CNT_W'(active_leaves_r);
    n_w       = (al_w < LEAF_LIMIT) ? al_w : LEAF_LIMIT;
    pt_ok     = (in_opcode <= OPC_READ) && (pos_w < n_w);
    rg_ok     = (in_opcode == OPC_RANGE) && (pos_w <= rb_w) && (rb_w <= n_w);
    leaf_addr = NW'(SPAN_EXT) | NW'(pos_w);
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign par_addr = node_r >> 1;
  assign r_dec    = r_r - 1'b1;

  // One shared fold unit; its operands follow the sequencer step.
  always_comb begin
    case (state_r)
      S_LEAF: begin
        comb_a = ram_rdata;
        comb_b = opnd_r;
      end
      S_UP: begin
        comb_a = node_r[0] ? ram_rdata : cur_r;
        comb_b = node_r[0] ? cur_r : ram_rdata;
      end
      S_QR: begin
        comb_a = accl_r;
        comb_b = ram_rdata;
      end
      S_QS: begin
        comb_a = ram_rdata;
        comb_b = accr_r;
      end
      default: begin
        comb_a = accl_r;
        comb_b = accr_r;
      end
    endcase
    comb_y = fold_combine(op_sel_r, comb_a, comb_b);
  end

  // Node read address for the next step.
  always_comb begin
    case (state_r)
      S_LEAF:  ram_raddr = node_r ^ NW'(1);
      S_UP:    ram_raddr = par_addr ^ NW'(1);
      S_QL:    ram_raddr = l_r[NW-1:0];
      S_QR:    ram_raddr = r_dec[NW-1:0];
      default: ram_raddr = leaf_addr;
    endcase
  end

  // Sequencer: clearing sweep, point read, leaf update with path rebuild, range fold.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    opc_nxt   = opc_r;
    node_nxt  = node_r;
    cur_nxt   = cur_r;
    opnd_nxt  = opnd_r;
    accl_nxt  = accl_r;
    accr_nxt  = accr_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    rodd_nxt  = rodd_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_waddr = node_r;
    ram_wdata = cur_r;

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          opc_nxt  = in_opcode;
          opnd_nxt = word_t'(in_operand_value);
          node_nxt = leaf_addr;
          l_nxt    = SPAN_EXT + (NW + 1)'(pos_w);
          r_nxt    = SPAN_EXT + (NW + 1)'(rb_w);
          accl_nxt = fold_identity(op_sel_r);
          accr_nxt = fold_identity(op_sel_r);
          res_nxt  = '0;
          st_nxt   = STATUS_ERR;
          if (pt_ok) begin
            state_nxt = S_LEAF;
          end else if (rg_ok) begin
            state_nxt = S_QL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_LEAF: begin
        st_nxt = STATUS_OK;
        if (opc_r == OPC_READ) begin
          res_nxt   = ram_rdata;
          state_nxt = S_DONE;
        end else begin
          case (opc_r)
            OPC_REPLACE: cur_nxt = opnd_r;
            OPC_ADD:     cur_nxt = ram_rdata + opnd_r;
            default:     cur_nxt = comb_y;
          endcase
          res_nxt   = cur_nxt;
          ram_we    = 1'b1;
          ram_waddr = node_r;
          ram_wdata = cur_nxt;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        // Parent from the carried child and its sibling just read.
        ram_we    = 1'b1;
        ram_waddr = par_addr;
        ram_wdata = comb_y;
        cur_nxt   = comb_y;
        node_nxt  = par_addr;
        if (par_addr == ROOT_ADDR) begin
          state_nxt = S_DONE;
        end
      end
      S_QL: begin
        if (l_r < r_r) begin
          state_nxt = S_QR;
        end else begin
          res_nxt   = comb_y;
          st_nxt    = STATUS_OK;
          state_nxt = S_DONE;
        end
      end
      S_QR: begin
        // Left edge takes the node read last step; right edge reads next.
        if (l_r[0]) begin
          accl_nxt = comb_y;
          l_nxt    = l_r + 1'b1;
        end
        rodd_nxt = r_r[0];
        if (r_r[0]) begin
          r_nxt = r_dec;
        end
        state_nxt = S_QS;
      end
      S_QS: begin
        if (rodd_r) begin
          accr_nxt = comb_y;
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = S_QL;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
      out_st_nxt    = st_r;
    end
  end

  // Configuration registers.
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    op_sel_nxt        = op_sel_r;
    active_leaves_nxt = active_leaves_r;
    if (cfg_we) begin
      if (paddr[2] == REG_ACTIVE_LEAVES) begin
        active_leaves_nxt = pwdata[LEAVES_W-1:0];
      end else begin
        op_sel_nxt = pwdata[FOLD_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OP_SELECT) ? 32'(op_sel_r) : 32'(active_leaves_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLR;
      clr_r           <= '0;
      op_sel_r        <= FOLD_SUM;
      active_leaves_r <= ACTIVE_LEAVES_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_r           <= clr_nxt;
      op_sel_r        <= op_sel_nxt;
      active_leaves_r <= active_leaves_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    opc_r     <= opc_nxt;
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    opnd_r    <= opnd_nxt;
    accl_r    <= accl_nxt;
    accr_r    <= accr_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    rodd_r    <= rodd_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    out_res_r <= out_res_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_res_r);
  assign out_status       = out_st_r;

  // A rejected beat always reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_result_value == '0))
    else $error("error status with nonzero result");

  // Range folding never modifies the tree.
  a_query_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QL || state_r == S_QR || state_r == S_QS) |-> !ram_we)
    else $error("node write during range query");

  // The path rebuild never runs past the root.
  a_up_child: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (node_r > ROOT_ADDR))
    else $error("path rebuild above root");

  // An accepted beat closes the input until its result is registered.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("second beat accepted while busy");

endmodule
